[src/rlc_pkg.sv]
// ============================================================================
// rlc_pkg - shared types and constants for the RLC low-pass step integrator
// Fixed-point format, saturation limits, register map, solver modes and the
// command and status words between the sequencer and the datapath.
// ============================================================================
package rlc_pkg;

    // number format
    localparam int FRAC_BITS  = 16;
    localparam int DATA_WIDTH = 32;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int RMAG_W     = PROD_W - FRAC_BITS;
    localparam int COEF_W     = 31;
    localparam int MODE_W     = 2;
    localparam int IN_W       = 3 * DATA_WIDTH;

    // configuration port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;
    localparam int IDX_W  = APB_AW - 2;

    // saturation limits
    localparam logic signed [DATA_WIDTH-1:0] VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] VMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [PROD_W-1:0] MAG_MAX =
        {{(PROD_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};

    // round to nearest at the binary point
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

    // divide by six: multiply by ceil(2^(W+2)/6), keep the top bits
    localparam int DIV6_SHIFT = DATA_WIDTH + 2;
    localparam logic [PROD_W:0] DIV6_RECIP_W =
        (((PROD_W+1)'(1) << DIV6_SHIFT) + (PROD_W+1)'(5)) / (PROD_W+1)'(6);
    localparam logic [DATA_WIDTH-1:0] DIV6_RECIP = DIV6_RECIP_W[DATA_WIDTH-1:0];

    // register indexes
    localparam logic [IDX_W-1:0] REG_STEP = 2'd0;
    localparam logic [IDX_W-1:0] REG_DAMP = 2'd1;
    localparam logic [IDX_W-1:0] REG_NAT  = 2'd2;
    localparam logic [IDX_W-1:0] REG_MODE = 2'd3;

    // reset values
    localparam logic [COEF_W-1:0] COEF_RESET = 31'd655;

    // solver modes
    localparam logic [MODE_W-1:0] MODE_EULER = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HEUN  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CHAIN = 2'd2;
    localparam logic [MODE_W-1:0] MODE_HOLD  = 2'd3;

    typedef struct packed {
        logic [COEF_W-1:0] step_size;
        logic [COEF_W-1:0] damping_gain;
        logic [COEF_W-1:0] natural_gain;
        logic [MODE_W-1:0] solver_mode;
    } cfg_t;

    // operand sources
    typedef enum logic [3:0] {
        SRC_U, SRC_V, SRC_VE0, SRC_VE1, SRC_VE2, SRC_VN, SRC_A,
        SRC_T, SRC_X, SRC_HV, SRC_NG, SRC_DG, SRC_H
    } src_t;

    // result destinations
    typedef enum logic [2:0] {
        DST_NONE, DST_U, DST_VN, DST_A, DST_T, DST_X, DST_HV
    } dst_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NOP,   // nothing
        OP_ADD,   // saturating a + b
        OP_SUB,   // saturating a - b
        OP_MUL,   // load product |a| * |b|
        OP_RND,   // round and saturate the product
        OP_DIV2,  // rounded a / 2
        OP_D6M,   // load product (|a| + 3) * reciprocal of six
        OP_D6R,   // signed quotient from that product
        OP_PASS   // a unchanged
    } op_t;

    typedef struct packed {
        op_t  op;
        src_t src_a;
        src_t src_b;
        dst_t dst;
        logic start;   // latch input word, clear clip flag
        logic commit;  // store state, load result word
    } cmd_t;

    typedef struct packed {
        logic out_free;  // result register can take a word this cycle
    } sts_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_R0_SUB, ST_R0_MN, ST_R0_RN, ST_R0_MD, ST_R0_RD, ST_R0_DIF, ST_VN,
        ST_E_MUL, ST_E_RND,
        ST_H_SUM, ST_H_MUL, ST_H_RND, ST_H_DIV,
        ST_C_MUL, ST_C_RND, ST_C_U1,
        ST_C1_SUB, ST_C1_MN, ST_C1_RN, ST_C1_MD, ST_C1_RD, ST_C1_DIF, ST_C_A,
        ST_C_U2A, ST_C_U2B,
        ST_C2_SUB, ST_C2_MN, ST_C2_RN, ST_C2_MD, ST_C2_RD, ST_C2_DIF, ST_C_B,
        ST_S_VV, ST_S_V, ST_S_AA, ST_S_ADDA, ST_S_ADDB,
        ST_S_MUL, ST_S_RND, ST_S_D6M, ST_S_D6R,
        ST_FIN, ST_HOLD
    } state_t;

endpackage

[src/rlc_cfg.sv]
// ============================================================================
// rlc_cfg - configuration registers
// APB-style register file for step size, the two gains and the solver mode.
// ============================================================================
module rlc_cfg
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rlc_pkg::APB_AW-1:0]   paddr,
    input  logic [rlc_pkg::APB_DW-1:0]   pwdata,
    output logic [rlc_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output rlc_pkg::cfg_t                cfg
);

    rlc_pkg::cfg_t              cfg_reg;
    logic [rlc_pkg::IDX_W-1:0]  idx;
    logic                       wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[rlc_pkg::APB_AW-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_size    <= rlc_pkg::COEF_RESET;
            cfg_reg.damping_gain <= rlc_pkg::COEF_RESET;
            cfg_reg.natural_gain <= rlc_pkg::COEF_RESET;
            cfg_reg.solver_mode  <= rlc_pkg::MODE_EULER;
        end
        else if (wr_en)
        begin
            unique case (idx)
                rlc_pkg::REG_STEP: cfg_reg.step_size    <= pwdata[rlc_pkg::COEF_W-1:0];
                rlc_pkg::REG_DAMP: cfg_reg.damping_gain <= pwdata[rlc_pkg::COEF_W-1:0];
                rlc_pkg::REG_NAT:  cfg_reg.natural_gain <= pwdata[rlc_pkg::COEF_W-1:0];
                rlc_pkg::REG_MODE: cfg_reg.solver_mode  <= pwdata[rlc_pkg::MODE_W-1:0];
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (idx)
            rlc_pkg::REG_STEP: prdata = rlc_pkg::APB_DW'(cfg_reg.step_size);
            rlc_pkg::REG_DAMP: prdata = rlc_pkg::APB_DW'(cfg_reg.damping_gain);
            rlc_pkg::REG_NAT:  prdata = rlc_pkg::APB_DW'(cfg_reg.natural_gain);
            rlc_pkg::REG_MODE: prdata = rlc_pkg::APB_DW'(cfg_reg.solver_mode);
        endcase
    end

endmodule

[src/rlc_ctrl.sv]
// ============================================================================
// rlc_ctrl - step sequencer
// Walks one integration step through the shared datapath, one operation a
// cycle unless output is full, choosing the voltage update by solver mode.
// ============================================================================
module rlc_ctrl
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [rlc_pkg::MODE_W-1:0]   mode,
    input  rlc_pkg::sts_t                sts,
    output rlc_pkg::cmd_t                cmd
);

    rlc_pkg::state_t state_reg;
    rlc_pkg::state_t state_next;

    function automatic rlc_pkg::cmd_t mk(input rlc_pkg::op_t op, input rlc_pkg::src_t sa,
                                         input rlc_pkg::src_t sb, input rlc_pkg::dst_t d);
        rlc_pkg::cmd_t c;
        c.op     = op;
        c.src_a  = sa;
        c.src_b  = sb;
        c.dst    = d;
        c.start  = 1'b0;
        c.commit = 1'b0;
        return c;
    endfunction

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rlc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rlc_pkg::ST_IDLE:   if (in_valid) state_next = rlc_pkg::ST_R0_SUB;
            rlc_pkg::ST_R0_SUB: state_next = rlc_pkg::ST_R0_MN;
            rlc_pkg::ST_R0_MN:  state_next = rlc_pkg::ST_R0_RN;
            rlc_pkg::ST_R0_RN:  state_next = rlc_pkg::ST_R0_MD;
            rlc_pkg::ST_R0_MD:  state_next = rlc_pkg::ST_R0_RD;
            rlc_pkg::ST_R0_RD:  state_next = rlc_pkg::ST_R0_DIF;
            rlc_pkg::ST_R0_DIF: state_next = rlc_pkg::ST_VN;
            rlc_pkg::ST_VN:
            begin
                unique case (mode)
                    rlc_pkg::MODE_EULER: state_next = rlc_pkg::ST_E_MUL;
                    rlc_pkg::MODE_HEUN:  state_next = rlc_pkg::ST_H_SUM;
                    rlc_pkg::MODE_CHAIN: state_next = rlc_pkg::ST_C_MUL;
                    rlc_pkg::MODE_HOLD:  state_next = rlc_pkg::ST_HOLD;
                endcase
            end
            rlc_pkg::ST_E_MUL:  state_next = rlc_pkg::ST_E_RND;
            rlc_pkg::ST_E_RND:  state_next = rlc_pkg::ST_FIN;
            rlc_pkg::ST_H_SUM:  state_next = rlc_pkg::ST_H_MUL;
            rlc_pkg::ST_H_MUL:  state_next = rlc_pkg::ST_H_RND;
            rlc_pkg::ST_H_RND:  state_next = rlc_pkg::ST_H_DIV;
            rlc_pkg::ST_H_DIV:  state_next = rlc_pkg::ST_FIN;
            rlc_pkg::ST_C_MUL:  state_next = rlc_pkg::ST_C_RND;
            rlc_pkg::ST_C_RND:  state_next = rlc_pkg::ST_C_U1;
            rlc_pkg::ST_C_U1:   state_next = rlc_pkg::ST_C1_SUB;
            rlc_pkg::ST_C1_SUB: state_next = rlc_pkg::ST_C1_MN;
            rlc_pkg::ST_C1_MN:  state_next = rlc_pkg::ST_C1_RN;
            rlc_pkg::ST_C1_RN:  state_next = rlc_pkg::ST_C1_MD;
            rlc_pkg::ST_C1_MD:  state_next = rlc_pkg::ST_C1_RD;
            rlc_pkg::ST_C1_RD:  state_next = rlc_pkg::ST_C1_DIF;
            rlc_pkg::ST_C1_DIF: state_next = rlc_pkg::ST_C_A;
            rlc_pkg::ST_C_A:    state_next = rlc_pkg::ST_C_U2A;
            rlc_pkg::ST_C_U2A:  state_next = rlc_pkg::ST_C_U2B;
            rlc_pkg::ST_C_U2B:  state_next = rlc_pkg::ST_C2_SUB;
            rlc_pkg::ST_C2_SUB: state_next = rlc_pkg::ST_C2_MN;
            rlc_pkg::ST_C2_MN:  state_next = rlc_pkg::ST_C2_RN;
            rlc_pkg::ST_C2_RN:  state_next = rlc_pkg::ST_C2_MD;
            rlc_pkg::ST_C2_MD:  state_next = rlc_pkg::ST_C2_RD;
            rlc_pkg::ST_C2_RD:  state_next = rlc_pkg::ST_C2_DIF;
            rlc_pkg::ST_C2_DIF: state_next = rlc_pkg::ST_C_B;
            rlc_pkg::ST_C_B:    state_next = rlc_pkg::ST_S_VV;
            rlc_pkg::ST_S_VV:   state_next = rlc_pkg::ST_S_V;
            rlc_pkg::ST_S_V:    state_next = rlc_pkg::ST_S_AA;
            rlc_pkg::ST_S_AA:   state_next = rlc_pkg::ST_S_ADDA;
            rlc_pkg::ST_S_ADDA: state_next = rlc_pkg::ST_S_ADDB;
            rlc_pkg::ST_S_ADDB: state_next = rlc_pkg::ST_S_MUL;
            rlc_pkg::ST_S_MUL:  state_next = rlc_pkg::ST_S_RND;
            rlc_pkg::ST_S_RND:  state_next = rlc_pkg::ST_S_D6M;
            rlc_pkg::ST_S_D6M:  state_next = rlc_pkg::ST_S_D6R;
            rlc_pkg::ST_S_D6R:  state_next = rlc_pkg::ST_FIN;
            rlc_pkg::ST_FIN,
            rlc_pkg::ST_HOLD:   if (sts.out_free) state_next = rlc_pkg::ST_IDLE;
            default:            state_next = rlc_pkg::ST_IDLE;
        endcase
    end

    // command per state
    always_comb
    begin
        cmd      = mk(rlc_pkg::OP_NOP, rlc_pkg::SRC_U, rlc_pkg::SRC_U, rlc_pkg::DST_NONE);
        in_ready = 1'b0;
        unique case (state_reg)
            rlc_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.start = in_valid;
            end
            // rate at t, then slope by Euler
            rlc_pkg::ST_R0_SUB: cmd = mk(rlc_pkg::OP_SUB, rlc_pkg::SRC_VE0, rlc_pkg::SRC_U,
                                         rlc_pkg::DST_T);
            rlc_pkg::ST_R0_MN:  cmd = mk(rlc_pkg::OP_MUL, rlc_pkg::SRC_NG, rlc_pkg::SRC_T,
                                         rlc_pkg::DST_NONE);
            rlc_pkg::ST_R0_RN:  cmd = mk(rlc_pkg::OP_RND, rlc_pkg::SRC_U, rlc_pkg::SRC_U,
                                         rlc_pkg::DST_T);
            rlc_pkg::ST_R0_MD:  cmd = mk(rlc_pkg::OP_MUL, rlc_pkg::SRC_DG, rlc_pkg::SRC_V,
                                         rlc_pkg::DST_NONE);
            rlc_pkg::ST_R0_RD:  cmd = mk(rlc_pkg::OP_RND, rlc_pkg::SRC_U, rlc_pkg::SRC_U,
                                         rlc_pkg::DST_X);
            rlc_pkg::ST_R0_DIF: cmd = mk(rlc_pkg::OP_SUB, rlc_pkg::SRC_T, rlc_pkg::SRC_X,
                                         rlc_pkg::DST_T);
            rlc_pkg::ST_VN:     cmd = mk(rlc_pkg::OP_ADD, rlc_pkg::SRC_V, rlc_pkg::SRC_T,
                                         rlc_pkg::DST_VN);
            // Euler voltage
            rlc_pkg::ST_E_MUL:  cmd = mk(rlc_pkg::OP_MUL, rlc_pkg::SRC_H, rlc_pkg::SRC_V,
                                         rlc_pkg::DST_NONE);
            rlc_pkg::ST_E_RND:  cmd = mk(rlc_pkg::OP_RND, rlc_pkg::SRC_U, rlc_pkg::SRC_U,
                                         rlc_pkg::DST_T);
            // Heun voltage
            rlc_pkg::ST_H_SUM:  cmd = mk(rlc_pkg::OP_ADD, rlc_pkg::SRC_V, rlc_pkg::SRC_VN,
                                         rlc_pkg::DST_T);
            rlc_pkg::ST_H_MUL:  cmd = mk(rlc_pkg::OP_MUL, rlc_pkg::SRC_H, rlc_pkg::SRC_T,
                                         rlc_pkg::DST_NONE);
            rlc_pkg::ST_H_RND:  cmd = mk(rlc_pkg::OP_RND, rlc_pkg::SRC_U, rlc_pkg::SRC_U,
                                         rlc_pkg::DST_T);
            rlc_pkg::ST_H_DIV:  cmd = mk(rlc_pkg::OP_DIV2, rlc_pkg::SRC_T, rlc_pkg::SRC_U,
                                         rlc_pkg::DST_T);
            // weighted chain: first predictor point
            rlc_pkg::ST_C_MUL:  cmd = mk(rlc_pkg::OP_MUL, rlc_pkg::SRC_H, rlc_pkg::SRC_V,
                                         rlc_pkg::DST_NONE);
            rlc_pkg::ST_C_RND:  cmd = mk(rlc_pkg::OP_RND, rlc_pkg::SRC_U, rlc_pkg::SRC_U,
                                         rlc_pkg::DST_HV);
            rlc_pkg::ST_C_U1:   cmd = mk(rlc_pkg::OP_ADD, rlc_pkg::SRC_U, rlc_pkg::SRC_HV,
                                         rlc_pkg::DST_X);
            rlc_pkg::ST_C1_SUB: cmd = mk(rlc_pkg::OP_SUB, rlc_pkg::SRC_VE1, rlc_pkg::SRC_X,
                                         rlc_pkg::DST_T);
            rlc_pkg::ST_C1_MN:  cmd = mk(rlc_pkg::OP_MUL, rlc_pkg::SRC_NG, rlc_pkg::SRC_T,
                                         rlc_pkg::DST_NONE);
            rlc_pkg::ST_C1_RN:  cmd = mk(rlc_pkg::OP_RND, rlc_pkg::SRC_U, rlc_pkg::SRC_U,
                                         rlc_pkg::DST_T);
            rlc_pkg::ST_C1_MD:  cmd = mk(rlc_pkg::OP_MUL, rlc_pkg::SRC_DG, rlc_pkg::SRC_VN,
                                         rlc_pkg::DST_NONE);
            rlc_pkg::ST_C1_RD:  cmd = mk(rlc_pkg::OP_RND, rlc_pkg::SRC_U, rlc_pkg::SRC_U,
                                         rlc_pkg::DST_X);
            rlc_pkg::ST_C1_DIF: cmd = mk(rlc_pkg::OP_SUB, rlc_pkg::SRC_T, rlc_pkg::SRC_X,
                                         rlc_pkg::DST_T);
            rlc_pkg::ST_C_A:    cmd = mk(rlc_pkg::OP_ADD, rlc_pkg::SRC_VN, rlc_pkg::SRC_T,
                                         rlc_pkg::DST_A);
            // second predictor point
            rlc_pkg::ST_C_U2A:  cmd = mk(rlc_pkg::OP_ADD, rlc_pkg::SRC_U, rlc_pkg::SRC_HV,
                                         rlc_pkg::DST_X);
            rlc_pkg::ST_C_U2B:  cmd = mk(rlc_pkg::OP_ADD, rlc_pkg::SRC_X, rlc_pkg::SRC_HV,
                                         rlc_pkg::DST_X);
            rlc_pkg::ST_C2_SUB: cmd = mk(rlc_pkg::OP_SUB, rlc_pkg::SRC_VE2, rlc_pkg::SRC_X,
                                         rlc_pkg::DST_T);
            rlc_pkg::ST_C2_MN:  cmd = mk(rlc_pkg::OP_MUL, rlc_pkg::SRC_NG, rlc_pkg::SRC_T,
                                         rlc_pkg::DST_NONE);
            rlc_pkg::ST_C2_RN:  cmd = mk(rlc_pkg::OP_RND, rlc_pkg::SRC_U, rlc_pkg::SRC_U,
                                         rlc_pkg::DST_T);
            rlc_pkg::ST_C2_MD:  cmd = mk(rlc_pkg::OP_MUL, rlc_pkg::SRC_DG, rlc_pkg::SRC_A,
                                         rlc_pkg::DST_NONE);
            rlc_pkg::ST_C2_RD:  cmd = mk(rlc_pkg::OP_RND, rlc_pkg::SRC_U, rlc_pkg::SRC_U,
                                         rlc_pkg::DST_X);
            rlc_pkg::ST_C2_DIF: cmd = mk(rlc_pkg::OP_SUB, rlc_pkg::SRC_T, rlc_pkg::SRC_X,
                                         rlc_pkg::DST_T);
            rlc_pkg::ST_C_B:    cmd = mk(rlc_pkg::OP_ADD, rlc_pkg::SRC_A, rlc_pkg::SRC_T,
                                         rlc_pkg::DST_X);
            // weighted sum v + 2vn + 2a + b, times h, over six
            rlc_pkg::ST_S_VV:   cmd = mk(rlc_pkg::OP_ADD, rlc_pkg::SRC_VN, rlc_pkg::SRC_VN,
                                         rlc_pkg::DST_T);
            rlc_pkg::ST_S_V:    cmd = mk(rlc_pkg::OP_ADD, rlc_pkg::SRC_V, rlc_pkg::SRC_T,
                                         rlc_pkg::DST_T);
            rlc_pkg::ST_S_AA:   cmd = mk(rlc_pkg::OP_ADD, rlc_pkg::SRC_A, rlc_pkg::SRC_A,
                                         rlc_pkg::DST_HV);
            rlc_pkg::ST_S_ADDA: cmd = mk(rlc_pkg::OP_ADD, rlc_pkg::SRC_T, rlc_pkg::SRC_HV,
                                         rlc_pkg::DST_T);
            rlc_pkg::ST_S_ADDB: cmd = mk(rlc_pkg::OP_ADD, rlc_pkg::SRC_T, rlc_pkg::SRC_X,
                                         rlc_pkg::DST_T);
            rlc_pkg::ST_S_MUL:  cmd = mk(rlc_pkg::OP_MUL, rlc_pkg::SRC_H, rlc_pkg::SRC_T,
                                         rlc_pkg::DST_NONE);
            rlc_pkg::ST_S_RND:  cmd = mk(rlc_pkg::OP_RND, rlc_pkg::SRC_U, rlc_pkg::SRC_U,
                                         rlc_pkg::DST_T);
            rlc_pkg::ST_S_D6M:  cmd = mk(rlc_pkg::OP_D6M, rlc_pkg::SRC_T, rlc_pkg::SRC_U,
                                         rlc_pkg::DST_NONE);
            rlc_pkg::ST_S_D6R:  cmd = mk(rlc_pkg::OP_D6R, rlc_pkg::SRC_U, rlc_pkg::SRC_U,
                                         rlc_pkg::DST_T);
            // final voltage and commit, held while the result register is full
            rlc_pkg::ST_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd = mk(rlc_pkg::OP_ADD, rlc_pkg::SRC_U, rlc_pkg::SRC_T, rlc_pkg::DST_U);
                    cmd.commit = 1'b1;
                end
            end
            rlc_pkg::ST_HOLD:
            begin
                if (sts.out_free)
                begin
                    cmd = mk(rlc_pkg::OP_PASS, rlc_pkg::SRC_U, rlc_pkg::SRC_U, rlc_pkg::DST_U);
                    cmd.commit = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

[src/rlc_dp.sv]
// ============================================================================
// rlc_dp - integrator datapath
// Working registers, a saturating adder, one shared 32x32 magnitude
// multiplier with a product register, rounding, halving and divide by six,
// plus the result register.
// ============================================================================
module rlc_dp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  rlc_pkg::cfg_t                 cfg,
    input  rlc_pkg::cmd_t                 cmd,
    output rlc_pkg::sts_t                 sts,
    input  logic [rlc_pkg::IN_W-1:0]      in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rlc_pkg::DATA_WIDTH-1:0] out_voltage,
    output logic                          out_sat
);

    localparam int W = rlc_pkg::DATA_WIDTH;

    // state and working registers
    logic signed [W-1:0] u_reg, v_reg;
    logic signed [W-1:0] ve0_reg, ve1_reg, ve2_reg;
    logic signed [W-1:0] vn_reg, a_reg, t_reg, x_reg, hv_reg;
    logic [rlc_pkg::PROD_W-1:0] prod_reg;
    logic                neg_reg;
    logic                sat_reg;
    logic                out_valid_reg;
    logic [W-1:0]        out_volt_reg;
    logic                out_sat_reg;

    // combinational
    logic signed [W-1:0] a_val, b_val;
    logic [W-1:0]        mag_a, mag_b;
    logic signed [W:0]   ext_a, ext_b, sum_w;
    logic                sum_ovf;
    logic signed [W-1:0] sum_val;
    logic [W-1:0]        mop_a, mop_b;
    logic [rlc_pkg::PROD_W-1:0] prod_next;
    logic                neg_next;
    logic [rlc_pkg::PROD_W-1:0] rsum;
    logic [rlc_pkg::RMAG_W-1:0] rmag;
    logic                rnd_ovf;
    logic [W-1:0]        rnd_q;
    logic signed [W-1:0] rnd_val;
    logic [W-1:0]        half_q;
    logic signed [W-1:0] half_val;
    logic [W-1:0]        d6_q;
    logic signed [W-1:0] d6_val;
    logic signed [W-1:0] res;
    logic                clip_now;

    function automatic logic signed [W-1:0] pick(input rlc_pkg::src_t s,
                                                  input logic signed [W-1:0] u,
                                                  input logic signed [W-1:0] v,
                                                  input logic signed [W-1:0] e0,
                                                  input logic signed [W-1:0] e1,
                                                  input logic signed [W-1:0] e2,
                                                  input logic signed [W-1:0] vn,
                                                  input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] t,
                                                  input logic signed [W-1:0] x,
                                                  input logic signed [W-1:0] hv,
                                                  input rlc_pkg::cfg_t c);
        logic signed [W-1:0] r;
        unique case (s)
            rlc_pkg::SRC_U:   r = u;
            rlc_pkg::SRC_V:   r = v;
            rlc_pkg::SRC_VE0: r = e0;
            rlc_pkg::SRC_VE1: r = e1;
            rlc_pkg::SRC_VE2: r = e2;
            rlc_pkg::SRC_VN:  r = vn;
            rlc_pkg::SRC_A:   r = a;
            rlc_pkg::SRC_T:   r = t;
            rlc_pkg::SRC_X:   r = x;
            rlc_pkg::SRC_HV:  r = hv;
            rlc_pkg::SRC_NG:  r = W'(c.natural_gain);
            rlc_pkg::SRC_DG:  r = W'(c.damping_gain);
            rlc_pkg::SRC_H:   r = W'(c.step_size);
            default:          r = '0;
        endcase
        return r;
    endfunction

    // operand selection and magnitudes
    always_comb
    begin
        a_val = pick(cmd.src_a, u_reg, v_reg, ve0_reg, ve1_reg, ve2_reg, vn_reg, a_reg,
                     t_reg, x_reg, hv_reg, cfg);
        b_val = pick(cmd.src_b, u_reg, v_reg, ve0_reg, ve1_reg, ve2_reg, vn_reg, a_reg,
                     t_reg, x_reg, hv_reg, cfg);
        mag_a = a_val[W-1] ? (~a_val + 1'b1) : a_val;
        mag_b = b_val[W-1] ? (~b_val + 1'b1) : b_val;
    end

    // saturating add / subtract
    always_comb
    begin
        ext_a   = {a_val[W-1], a_val};
        ext_b   = {b_val[W-1], b_val};
        sum_w   = (cmd.op == rlc_pkg::OP_SUB) ? (ext_a - ext_b) : (ext_a + ext_b);
        sum_ovf = sum_w[W] != sum_w[W-1];
        sum_val = sum_ovf ? (sum_w[W] ? rlc_pkg::VMIN : rlc_pkg::VMAX) : sum_w[W-1:0];
    end

    // shared multiplier, product registered
    always_comb
    begin
        if (cmd.op == rlc_pkg::OP_D6M)
        begin
            mop_a    = mag_a + W'(3);
            mop_b    = rlc_pkg::DIV6_RECIP;
            neg_next = a_val[W-1];
        end
        else
        begin
            mop_a    = mag_a;
            mop_b    = mag_b;
            neg_next = a_val[W-1] ^ b_val[W-1];
        end
        prod_next = rlc_pkg::PROD_W'(mop_a) * rlc_pkg::PROD_W'(mop_b);
    end

    // round at the binary point and saturate by sign
    always_comb
    begin
        rsum  = prod_reg + rlc_pkg::ROUND_HALF;
        rmag  = rsum[rlc_pkg::PROD_W-1:rlc_pkg::FRAC_BITS];
        if (neg_reg)
            rnd_ovf = rmag > (rlc_pkg::RMAG_W'(rlc_pkg::MAG_MAX) + rlc_pkg::RMAG_W'(1));
        else
            rnd_ovf = rmag > rlc_pkg::RMAG_W'(rlc_pkg::MAG_MAX);
        rnd_q = rmag[W-1:0];
        if (rnd_ovf)
            rnd_val = neg_reg ? rlc_pkg::VMIN : rlc_pkg::VMAX;
        else
            rnd_val = neg_reg ? (~rnd_q + 1'b1) : rnd_q;
    end

    // halving (ties away from zero) and quotient by six
    always_comb
    begin
        half_q   = W'(({1'b0, mag_a} + (W+1)'(1)) >> 1);
        half_val = a_val[W-1] ? (~half_q + 1'b1) : half_q;
        d6_q     = W'(prod_reg[rlc_pkg::PROD_W-1:rlc_pkg::DIV6_SHIFT]);
        d6_val   = neg_reg ? (~d6_q + 1'b1) : d6_q;
    end

    // result select
    always_comb
    begin
        res      = a_val;
        clip_now = 1'b0;
        unique case (cmd.op)
            rlc_pkg::OP_ADD,
            rlc_pkg::OP_SUB:
            begin
                res      = sum_val;
                clip_now = sum_ovf;
            end
            rlc_pkg::OP_RND:
            begin
                res      = rnd_val;
                clip_now = rnd_ovf;
            end
            rlc_pkg::OP_DIV2: res = half_val;
            rlc_pkg::OP_D6R:  res = d6_val;
            rlc_pkg::OP_NOP,
            rlc_pkg::OP_MUL,
            rlc_pkg::OP_D6M,
            rlc_pkg::OP_PASS: res = a_val;
            default:          res = a_val;
        endcase
    end

    // stored state, clip flag and result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_reg         <= '0;
            v_reg         <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.dst == rlc_pkg::DST_U)
                u_reg <= res;
            if (cmd.commit)
                v_reg <= vn_reg;
            if (cmd.start)
                sat_reg <= 1'b0;
            else if (clip_now)
                sat_reg <= 1'b1;
            if (cmd.commit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            ve0_reg <= in_data[0*W +: W];
            ve1_reg <= in_data[1*W +: W];
            ve2_reg <= in_data[2*W +: W];
        end
        if (cmd.op == rlc_pkg::OP_MUL || cmd.op == rlc_pkg::OP_D6M)
        begin
            prod_reg <= prod_next;
            neg_reg  <= neg_next;
        end
        unique case (cmd.dst)
            rlc_pkg::DST_VN:   vn_reg <= res;
            rlc_pkg::DST_A:    a_reg  <= res;
            rlc_pkg::DST_T:    t_reg  <= res;
            rlc_pkg::DST_X:    x_reg  <= res;
            rlc_pkg::DST_HV:   hv_reg <= res;
            rlc_pkg::DST_NONE,
            rlc_pkg::DST_U:    ;
            default:           ;
        endcase
        if (cmd.commit)
        begin
            out_volt_reg <= res;
            out_sat_reg  <= sat_reg | clip_now;
        end
    end

    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign out_voltage  = out_volt_reg;
    assign out_sat      = out_sat_reg;

endmodule

[src/rlc_lowpass_ode_step.sv]
// ============================================================================
// rlc_lowpass_ode_step - series RLC low-pass integrator, one step per word
// Top level: configuration registers, step sequencer and datapath.
// ============================================================================
// Each input word carries the source voltage at t, t+h and t+2h (Q16.16) and
// yields one result word with the new output voltage and a clip flag. The
// slope always advances by explicit Euler; solver_mode picks the voltage
// update (Euler, Heun, three-point weighted chain, or hold for the spare
// code). All work runs through one shared 32x32 multiplier and one adder,
// one operation a cycle unless the step stalls, and a new word is only
// taken once the previous step is through. The next word is taken while a
// result still waits in the output register; the step stalls in its final
// state only if that register is still full. Configuration is to be written
// through the APB port only while the block is idle; the block itself does
// not enforce this.
module rlc_lowpass_ode_step
(
    input  logic                          clk,
    input  logic                          rst_n,
    // input words
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [31:0] source_now, [63:32] source_next, [95:64] source_next2
    input  logic [rlc_pkg::IN_W-1:0]      s_tdata,
    // result words
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [31:0] out_voltage
    output logic [rlc_pkg::DATA_WIDTH-1:0] m_tdata,
    // [0] saturated
    output logic [0:0]                    m_tuser,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rlc_pkg::APB_AW-1:0]    paddr,
    input  logic [rlc_pkg::APB_DW-1:0]    pwdata,
    output logic [rlc_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    rlc_pkg::cfg_t cfg;
    rlc_pkg::cmd_t cmd;
    rlc_pkg::sts_t sts;
    logic          sat_bit;

    rlc_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rlc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .mode     (cfg.solver_mode),
        .sts      (sts),
        .cmd      (cmd)
    );

    rlc_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .sts         (sts),
        .in_data     (s_tdata),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_voltage (m_tdata),
        .out_sat     (sat_bit)
    );

    assign m_tuser[0] = sat_bit;

endmodule

[src/rlc_chk.sv]
// ============================================================================
// rlc_chk - port-level checks for the RLC integrator
// Handshake and sequencing properties seen on the top-level ports, bound to
// the top level.
// ============================================================================
module rlc_chk
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [rlc_pkg::DATA_WIDTH-1:0] m_tdata,
    input  logic [0:0]                    m_tuser,
    input  logic                          psel,
    input  logic                          pready
);

    // a stalled result word stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    // a stalled result word keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // one word at a time: the step is busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a step is in progress");

    // a fresh result appears only as the sequencer returns to idle
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> s_tready)
        else $error("result issued while the sequencer is busy");

    // register port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        psel |-> pready)
        else $error("pready low during an access");

endmodule

bind rlc_lowpass_ode_step rlc_chk u_rlc_chk (.*);
